FILE: rtl/mfr_pkg.sv
// Shared types and constants of the message frame receiver.
`default_nettype none

package mfr_pkg;

  // Header layout
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HDR_IDX_W    = 3;
  localparam logic [7:0]  MAGIC_FIRST  = 8'h4D;  // 'M'
  localparam logic [7:0]  MAGIC_SECOND = 8'h51;  // 'Q'

  // Bit positions in the frame type byte
  localparam int unsigned TYPE_START_BIT = 0;
  localparam int unsigned TYPE_END_BIT   = 1;
  localparam int unsigned TYPE_W         = 2;

  // Header byte positions that carry a check of their own
  localparam logic [HDR_IDX_W-1:0] HDR_MAGIC0 = 3'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_MAGIC1 = 3'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_TYPE   = 3'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_PAD    = 3'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 3'(HEADER_BYTES - 1);

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_LEN = 1'b0;

  typedef enum logic [0:0] {
    CMD_DATA    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_HEADER   = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        message_done;
    logic [31:0] message_length;
    logic [1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/mfr_if.sv
// Request channel interfaces of the message frame receiver.
`default_nettype none

interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        message_done;
  logic [31:0] message_length;
  logic [1:0]  error_code;

  modport source (output valid, output payload_valid, output payload_byte,
                  output message_done, output message_length, output error_code,
                  input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input message_done, input message_length, input error_code,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/message_frame_receiver.sv
// Top level of the message frame receiver: input register, deframer, result register.
// Usage:
//   in_ch carries one request per received stream byte: command DATA with the
//   byte, or command RESTART to discard the current message and clear a sticky
//   error. out_ch returns exactly one result per request, in order: the payload
//   byte when it is payload, a message-done flag, the running message length
//   and the error code.
//   The cfg_ port is an APB-style slave with one register, max_message_len at
//   byte address 0 (0 means no limit); write it only while the block is idle.
// Flow:
//   A request accepted into the input register is processed as it moves into
//   the result register, and its result is valid from then on. One request
//   per cycle is sustained while out_ch.ready is high; the deframer state is read
//   and written in the same cycle, so back-to-back bytes see each other's effect.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears the
//   deframer state and sets max_message_len to 0.
// Stall:
//   When out_ch.ready is low with a result shown, the result register holds; the
//   input register keeps at most one further request, and in_ch.ready drops until
//   the result is taken.
`default_nettype none

module message_frame_receiver #(
  parameter int unsigned FRAME_WIDTH_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mfr_in_if.sink                               in_ch,
  mfr_out_if.source                            out_ch,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [mfr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [mfr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [mfr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  logic [31:0] max_len;

  // input register
  logic       in_valid_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;

  // result register
  logic             out_valid_r;
  mfr_pkg::result_t out_res_r;
  mfr_pkg::result_t res;

  logic out_free;   // result register can take a new result
  logic step;       // process the held request this cycle
  logic in_take;

  mfr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .max_len (max_len)
  );

  mfr_deframer #(
    .FRAME_WIDTH_BITS (FRAME_WIDTH_BITS)
  ) u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .command   (in_cmd_r),
    .data_byte (in_byte_r),
    .max_len   (max_len),
    .res       (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && out_free;
  // the input register takes a new request when empty or when its request moves on
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // advance the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_ch.command;
      in_byte_r <= in_ch.data_byte;
    end
  end

  // load a result, or drop the shown one once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_valid  = out_res_r.payload_valid;
  assign out_ch.payload_byte   = out_res_r.payload_byte;
  assign out_ch.message_done   = out_res_r.message_done;
  assign out_ch.message_length = out_res_r.message_length;
  assign out_ch.error_code     = out_res_r.error_code;

endmodule

`default_nettype wire

FILE: rtl/mfr_apb_regs.sv
// APB-style configuration register of the message frame receiver.
`default_nettype none

module mfr_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mfr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [mfr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [mfr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic      [31:0]                      max_len
);

  logic [mfr_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                          wr_en;
  logic [31:0]                   max_len_r;

  assign reg_idx = paddr[mfr_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '0;
    end else if (wr_en && reg_idx == mfr_pkg::REG_MAX_MESSAGE_LEN) begin
      max_len_r <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfr_pkg::REG_MAX_MESSAGE_LEN: prdata = max_len_r;
      default:                      prdata = '0;
    endcase
  end

  assign max_len = max_len_r;

endmodule

`default_nettype wire

FILE: rtl/mfr_deframer.sv
// Deframing state and per-byte header, payload and length logic.
`default_nettype none

module mfr_deframer #(
  parameter int unsigned FRAME_WIDTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  command,
  input  wire logic [7:0]            data_byte,
  input  wire logic [31:0]           max_len,
  output mfr_pkg::result_t           res
);

  localparam int unsigned REM_W = FRAME_WIDTH_BITS + 1;
  localparam logic [32:0] MAX_FRAME = 33'(1) << FRAME_WIDTH_BITS;
  localparam logic [REM_W-1:0] REM_ONE = REM_W'(1);

  logic [mfr_pkg::HDR_IDX_W-1:0] hidx_r, hidx_nxt;
  logic [mfr_pkg::TYPE_W-1:0]    type_r, type_nxt;
  logic                          hok_r, hok_nxt;
  logic [31:0]                   shift_r, shift_nxt;
  logic [REM_W-1:0]              rem_r, rem_nxt;
  logic                          seen_r, seen_nxt;
  logic [31:0]                   total_r, total_nxt;
  mfr_pkg::err_t                 err_r, err_nxt;

  logic        hok;
  logic        frame_ok;
  logic        done;
  logic [31:0] frame_len;
  logic [32:0] sum;

  assign frame_len = {shift_r[23:0], data_byte};
  assign sum       = {1'b0, total_r} + {1'b0, frame_len};

  always_comb begin
    hidx_nxt  = hidx_r;
    type_nxt  = type_r;
    hok_nxt   = hok_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    seen_nxt  = seen_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    hok       = hok_r;
    frame_ok  = 1'b0;
    done      = 1'b0;
    res       = '0;

    if (command == mfr_pkg::CMD_RESTART) begin
      hidx_nxt  = '0;
      type_nxt  = '0;
      hok_nxt   = 1'b1;
      shift_nxt = '0;
      rem_nxt   = '0;
      seen_nxt  = 1'b0;
      total_nxt = '0;
      err_nxt   = mfr_pkg::ERR_NONE;
    end else if (err_r != mfr_pkg::ERR_NONE) begin
      // drop the byte, error holds until restart
    end else if (rem_r != '0) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = data_byte;
      rem_nxt           = rem_r - REM_ONE;
      if (rem_r == REM_ONE) begin
        done     = type_r[mfr_pkg::TYPE_END_BIT];
        seen_nxt = 1'b1;
      end
    end else begin
      case (hidx_r)
        mfr_pkg::HDR_MAGIC0: if (data_byte != mfr_pkg::MAGIC_FIRST)  hok = 1'b0;
        mfr_pkg::HDR_MAGIC1: if (data_byte != mfr_pkg::MAGIC_SECOND) hok = 1'b0;
        mfr_pkg::HDR_TYPE: begin
          type_nxt = data_byte[mfr_pkg::TYPE_W-1:0];
          if (data_byte[7:mfr_pkg::TYPE_W] != '0) hok = 1'b0;
        end
        mfr_pkg::HDR_PAD:    if (data_byte != 8'h00) hok = 1'b0;
        default:             shift_nxt = frame_len;
      endcase
      hok_nxt  = hok;
      hidx_nxt = hidx_r + 1'b1;

      if (hidx_r == mfr_pkg::HDR_LAST) begin
        hidx_nxt  = '0;
        hok_nxt   = 1'b1;
        shift_nxt = '0;
        frame_ok  = hok && (type_r[mfr_pkg::TYPE_START_BIT] != seen_r) &&
                    ({1'b0, frame_len} <= MAX_FRAME);
        if (!frame_ok) begin
          err_nxt = mfr_pkg::ERR_HEADER;
        end else begin
          if (sum[32]) begin
            total_nxt = '1;
            err_nxt   = mfr_pkg::ERR_TOO_LONG;
          end else begin
            total_nxt = sum[31:0];
            if (max_len != '0 && sum[31:0] > max_len) begin
              err_nxt = mfr_pkg::ERR_TOO_LONG;
            end
          end
          if (err_nxt == mfr_pkg::ERR_NONE) begin
            if (frame_len == '0) begin
              done     = type_r[mfr_pkg::TYPE_END_BIT];
              seen_nxt = 1'b1;
            end else begin
              rem_nxt = frame_len[REM_W-1:0];
            end
          end
        end
      end
    end

    res.message_done   = done;
    res.message_length = total_nxt;
    res.error_code     = err_nxt;

    // message finished: start the next one afresh
    if (done) begin
      total_nxt = '0;
      seen_nxt  = 1'b0;
      type_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r  <= '0;
      type_r  <= '0;
      hok_r   <= 1'b1;
      shift_r <= '0;
      rem_r   <= '0;
      seen_r  <= 1'b0;
      total_r <= '0;
      err_r   <= mfr_pkg::ERR_NONE;
    end else if (step) begin
      hidx_r  <= hidx_nxt;
      type_r  <= type_nxt;
      hok_r   <= hok_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
      total_r <= total_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire
